// ===== rtl/core/rfps_pkg.sv =====
package rfps_pkg;

    // Fixed field widths of the word on each channel.
    localparam int ACTION_W  = 2;
    localparam int DATA_W    = 8;
    localparam int PATTERN_W = 64;
    localparam int PLEN_W    = 4;
    localparam int STATUS_W  = 2;
    localparam int OFFSET_W  = 6;
    localparam int CAP_CFG_W = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT  = 2'd0,
        ACT_GET  = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_FIND = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_RESP = 2'd2
    } state_t;

    // Control from the sequencer to the pattern compare unit.
    typedef struct packed {
        logic load;
        logic shift;
    } match_ctrl_t;

endpackage

// ===== rtl/core/rfps_if.sv =====
interface rfps_in_if
    import rfps_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [DATA_W-1:0]    data_in;
    logic [PATTERN_W-1:0] pattern;
    logic [PLEN_W-1:0]    pattern_len;

    modport source (
        output valid,
        output action,
        output data_in,
        output pattern,
        output pattern_len,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  data_in,
        input  pattern,
        input  pattern_len,
        output ready
    );
endinterface

interface rfps_out_if
    import rfps_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
    logic [OFFSET_W-1:0] match_offset;
    logic                is_empty;
    logic                is_full;

    modport source (
        output valid,
        output status,
        output data_out,
        output match_offset,
        output is_empty,
        output is_full,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  data_out,
        input  match_offset,
        input  is_empty,
        input  is_full,
        output ready
    );
endinterface

// ===== rtl/core/rfps_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module rfps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/rfps_match.sv =====
// Sliding window of the most recent bytes read during a search, compared
// against the held pattern. The newest byte sits at window position zero.
module rfps_match
    import rfps_pkg::*;
#(
    parameter int MAX_PATTERN = 8
)(
    input  logic                 clk,
    input  match_ctrl_t          ctrl,
    input  logic [PATTERN_W-1:0] pattern,
    input  logic [PLEN_W-1:0]    plen,
    input  logic [DATA_W-1:0]    byte_in,
    output logic                 hit
);
    logic [DATA_W-1:0] pat_reg [MAX_PATTERN];
    logic [DATA_W-1:0] win_reg [MAX_PATTERN];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                pat_reg[i] <= pattern[DATA_W*i +: DATA_W];
            end
        end
        if (ctrl.shift)
        begin
            win_reg[0] <= byte_in;
            for (int k = 1; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    // Pattern byte i must equal the byte plen-1-i places back from the newest.
    always_comb
    begin
        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if ((PLEN_W'(i) < plen) &&
                    (PLEN_W'(j) == plen - PLEN_W'(i) - PLEN_W'(1)) &&
                    (win_reg[j] != pat_reg[i]))
                begin
                    hit = 1'b0;
                end
            end
        end
    end
endmodule

// ===== rtl/core/ring_fifo_with_pattern_search.sv =====
// Byte ring FIFO with pattern search. The ring holds up to capacity minus one
// bytes in a single-port-read RAM of DEPTH slots; writing the capacity register
// (values of zero act as one, values above DEPTH act as DEPTH) empties the ring.
// Each input word carries one action: put, get, peek or find. For put, get and
// peek the word is accepted, and the result is loaded into the output register
// on the following cycle, once the RAM's registered read data is available.
// Find streams the held bytes, oldest first, through the one RAM read port at
// one byte per cycle into a window compared against the pattern, and stops early
// when a match turns up; a find whose length is zero, above MAX_PATTERN or above
// the fill level answers not found without a search. No new word is taken while
// an action is in progress or while a result waits in the output register and
// is not being taken in that cycle. There is no clearing pass: only slots
// written by put are ever read back.
module ring_fifo_with_pattern_search
    import rfps_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int MAX_PATTERN = 8
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CAP_CFG_W-1:0] cfg_data,
    rfps_in_if.sink              item,
    rfps_out_if.source           result
);
    // Slot pointers index the RAM; capacity and counts must reach DEPTH itself.
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CAP_W     = $clog2(DEPTH + 1);
    localparam int EXT_W     = (CAP_W > OFFSET_W) ? CAP_W : OFFSET_W;
    localparam int CAP_RESET = (DEPTH < 64) ? DEPTH : 64;

    // Next slot after pos, wrapping at the programmed capacity.
    function automatic logic [PTR_W-1:0] step_pos(input logic [PTR_W-1:0] pos,
                                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] n;
        n = CAP_W'(pos) + CAP_W'(1);
        return (n >= cap) ? '0 : n[PTR_W-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [PTR_W-1:0] wr_pos_reg, wr_pos_next;
    logic [PTR_W-1:0] rd_pos_reg, rd_pos_next;

    // Result being prepared for the output register.
    status_t             status_reg, status_next;
    logic                use_rdata_reg, use_rdata_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;

    // Search sequencer.
    logic [CAP_W-1:0]  fill_reg, fill_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [PTR_W-1:0]  scan_addr_reg, scan_addr_next;
    logic [CAP_W-1:0]  iss_cnt_reg, iss_cnt_next;
    logic [CAP_W-1:0]  rcv_cnt_reg, rcv_cnt_next;
    logic              pend_reg, pend_next;
    logic              chk_reg, chk_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic [OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic                out_empty_reg, out_empty_next;
    logic                out_full_reg, out_full_next;

    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [PTR_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    match_ctrl_t mctrl;
    logic        hit;

    logic             accept;
    action_t          act;
    logic             ring_empty;
    logic             ring_full;
    logic [CAP_W-1:0] fill_now;
    logic             plen_ok;
    logic             found_now;
    logic             miss_now;
    logic             scan_done;
    logic [EXT_W-1:0] off_ext;
    logic [CAP_W-1:0] cap_wr;

    rfps_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rfps_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .clk     (clk),
        .ctrl    (mctrl),
        .pattern (item.pattern),
        .plen    (plen_reg),
        .byte_in (ram_rdata),
        .hit     (hit)
    );

    // A word is taken only in idle, and only when the output register is free
    // or is being emptied at the same edge.
    assign item.ready = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;
    assign act        = action_t'(item.action);

    assign ring_empty = (wr_pos_reg == rd_pos_reg);
    assign ring_full  = (step_pos(wr_pos_reg, cap_reg) == rd_pos_reg);
    assign fill_now   = (wr_pos_reg >= rd_pos_reg)
                      ? (CAP_W'(wr_pos_reg) - CAP_W'(rd_pos_reg))
                      : (cap_reg - CAP_W'(rd_pos_reg) + CAP_W'(wr_pos_reg));

    assign plen_ok = (item.pattern_len != '0) &&
                     (32'(item.pattern_len) <= MAX_PATTERN) &&
                     (EXT_W'(item.pattern_len) <= EXT_W'(fill_now));

    // The window is checked in the cycle after each byte enters it; a match ends
    // at the byte last received, so its offset is the count minus the length.
    assign off_ext   = EXT_W'(rcv_cnt_reg) - EXT_W'(plen_reg);
    assign found_now = chk_reg && (EXT_W'(rcv_cnt_reg) >= EXT_W'(plen_reg)) && hit;
    assign miss_now  = chk_reg && !found_now && (rcv_cnt_reg == fill_reg);
    assign scan_done = found_now || miss_now;

    // Capacity written as zero acts as one; above DEPTH it saturates.
    assign cap_wr = (cfg_data == '0)              ? CAP_W'(1)
                  : (32'(cfg_data) > DEPTH)       ? CAP_W'(DEPTH)
                  :                                 CAP_W'(cfg_data);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ((act == ACT_FIND) && plen_ok) ? S_SCAN : S_RESP;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cap_next        = cap_reg;
        wr_pos_next     = wr_pos_reg;
        rd_pos_next     = rd_pos_reg;
        status_next     = status_reg;
        use_rdata_next  = use_rdata_reg;
        offset_next     = offset_reg;
        fill_next       = fill_reg;
        plen_next       = plen_reg;
        scan_addr_next  = scan_addr_reg;
        iss_cnt_next    = iss_cnt_reg;
        rcv_cnt_next    = rcv_cnt_reg;
        pend_next       = pend_reg;
        chk_next        = chk_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_offset_next = out_offset_reg;
        out_empty_next  = out_empty_reg;
        out_full_next   = out_full_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_pos_reg;
        ram_wdata       = item.data_in;
        ram_raddr       = rd_pos_reg;
        mctrl           = '0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    use_rdata_next = 1'b0;
                    offset_next    = '0;
                    unique case (act)
                        ACT_PUT:
                        begin
                            if (ring_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                ram_we      = 1'b1;
                                wr_pos_next = step_pos(wr_pos_reg, cap_reg);
                            end
                        end
                        ACT_GET, ACT_PEEK:
                        begin
                            // The read of the oldest slot is issued now and
                            // lands in the response cycle.
                            if (ring_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                status_next    = ST_OK;
                                use_rdata_next = 1'b1;
                                if (act == ACT_GET)
                                begin
                                    rd_pos_next = step_pos(rd_pos_reg, cap_reg);
                                end
                            end
                        end
                        ACT_FIND:
                        begin
                            status_next = ST_NOTFOUND;
                            if (plen_ok)
                            begin
                                mctrl.load     = 1'b1;
                                fill_next      = fill_now;
                                plen_next      = item.pattern_len;
                                scan_addr_next = rd_pos_reg;
                                iss_cnt_next   = '0;
                                rcv_cnt_next   = '0;
                                pend_next      = 1'b0;
                                chk_next       = 1'b0;
                            end
                        end
                        default:
                        begin
                            status_next = ST_NOTFOUND;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                ram_raddr = scan_addr_reg;
                pend_next = (iss_cnt_reg < fill_reg);
                if (iss_cnt_reg < fill_reg)
                begin
                    scan_addr_next = step_pos(scan_addr_reg, cap_reg);
                    iss_cnt_next   = iss_cnt_reg + CAP_W'(1);
                end
                chk_next = pend_reg;
                if (pend_reg)
                begin
                    mctrl.shift  = 1'b1;
                    rcv_cnt_next = rcv_cnt_reg + CAP_W'(1);
                end
                if (found_now)
                begin
                    status_next = ST_OK;
                    offset_next = off_ext[OFFSET_W-1:0];
                end
            end
            S_RESP:
            begin
                out_valid_next  = 1'b1;
                out_status_next = status_reg;
                out_data_next   = use_rdata_reg ? ram_rdata : '0;
                out_offset_next = offset_reg;
                out_empty_next  = ring_empty;
                out_full_next   = ring_full;
            end
            default:
            begin
            end
        endcase

        // Configuration must arrive only while idle (the block itself does not enforce it); any write empties the ring.
        if (cfg_we)
        begin
            cap_next    = cap_wr;
            wr_pos_next = '0;
            rd_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_W'(CAP_RESET);
            wr_pos_reg    <= '0;
            rd_pos_reg    <= '0;
            pend_reg      <= 1'b0;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            wr_pos_reg    <= wr_pos_next;
            rd_pos_reg    <= rd_pos_next;
            pend_reg      <= pend_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        use_rdata_reg  <= use_rdata_next;
        offset_reg     <= offset_next;
        fill_reg       <= fill_next;
        plen_reg       <= plen_next;
        scan_addr_reg  <= scan_addr_next;
        iss_cnt_reg    <= iss_cnt_next;
        rcv_cnt_reg    <= rcv_cnt_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_offset_reg <= out_offset_next;
        out_empty_reg  <= out_empty_next;
        out_full_reg   <= out_full_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.data_out     = out_data_reg;
    assign result.match_offset = out_offset_reg;
    assign result.is_empty     = out_empty_reg;
    assign result.is_full      = out_full_reg;
endmodule

// ===== rtl/core/rfps_checker.sv =====
module rfps_assertions
    import rfps_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [DATA_W-1:0]   data_out,
    input logic [OFFSET_W-1:0] match_offset,
    input logic                is_empty,
    input logic                is_full
);
    // A stalled result word holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(data_out) && $stable(match_offset))
        else $error("result word changed while stalled");

    // Every action leaves the idle state, so words never arrive back to back.
    a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input word accepted in consecutive cycles");

    // A rejected put leaves the ring full.
    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> is_full)
        else $error("full status without full flag");

    // A rejected read leaves the ring empty.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> is_empty)
        else $error("empty status without empty flag");

    // Data and offset are zero on any failed action.
    a_zero_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (data_out == '0) && (match_offset == '0))
        else $error("payload not zero on failed action");
endmodule

bind ring_fifo_with_pattern_search rfps_assertions u_rfps_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item.valid),
    .in_ready     (item.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .status       (result.status),
    .data_out     (result.data_out),
    .match_offset (result.match_offset),
    .is_empty     (result.is_empty),
    .is_full      (result.is_full)
);

// ===== test/rfps_checker.sv =====
module rfps_checker
    import rfps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CAP_CFG_W-1:0] cfg_data,
    rfps_in_if                   item,
    rfps_out_if                  result,
    output int                   mismatch_count,
    output int                   results_owed
);

    localparam int RING_DEPTH    = 64;
    localparam int PATTERN_BYTES = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   data_out;
        logic [OFFSET_W-1:0] match_offset;
        logic                is_empty;
        logic                is_full;
    } ring_result_t;

    logic [DATA_W-1:0] ring_bytes [RING_DEPTH];
    int unsigned       head_pos;
    int unsigned       tail_pos;
    int unsigned       ring_slots;
    ring_result_t      awaited_results [$];

    function automatic int unsigned next_slot(int unsigned pos);
        return (pos + 1 >= ring_slots) ? 0 : pos + 1;
    endfunction

    function automatic int unsigned held_count();
        return (tail_pos >= head_pos) ? tail_pos - head_pos
                                      : ring_slots - head_pos + tail_pos;
    endfunction

    function automatic logic [DATA_W-1:0] byte_at(int unsigned offset);
        return ring_bytes[(head_pos + offset) % ring_slots];
    endfunction

    // Applies one word to the ring image and returns the result it should give.
    function automatic ring_result_t apply_ring_action(
        action_t                act,
        logic [DATA_W-1:0]      din,
        logic [PATTERN_W-1:0]   pat,
        logic [PLEN_W-1:0]      plen
    );
        ring_result_t r;
        int unsigned  fill;
        int unsigned  len;
        bit           hit;
        r        = '0;
        r.status = ST_OK;
        len      = 32'(plen);
        case (act)
            ACT_PUT:
            begin
                if (next_slot(tail_pos) == head_pos)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    ring_bytes[tail_pos] = din;
                    tail_pos = next_slot(tail_pos);
                end
            end
            ACT_GET, ACT_PEEK:
            begin
                if (tail_pos == head_pos)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.data_out = byte_at(0);
                    if (act == ACT_GET)
                    begin
                        head_pos = next_slot(head_pos);
                    end
                end
            end
            default:
            begin
                fill     = held_count();
                r.status = ST_NOTFOUND;
                if (len != 0 && len <= PATTERN_BYTES && len <= fill)
                begin
                    for (int unsigned off = 0;
                         off + len <= fill && r.status != ST_OK; off++)
                    begin
                        hit = 1'b1;
                        for (int unsigned i = 0; i < len; i++)
                        begin
                            if (byte_at(off + i) != pat[8*i +: 8])
                            begin
                                hit = 1'b0;
                            end
                        end
                        if (hit)
                        begin
                            r.status       = ST_OK;
                            r.match_offset = off[OFFSET_W-1:0];
                        end
                    end
                end
            end
        endcase
        r.is_empty = (tail_pos == head_pos);
        r.is_full  = (next_slot(tail_pos) == head_pos);
        return r;
    endfunction

    task automatic note_mismatch(string field, longint unsigned want, longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ring_result_t got;
        ring_result_t want;
        int unsigned  req;
        if (!rst_n)
        begin
            head_pos       = 0;
            tail_pos       = 0;
            ring_slots     = RING_DEPTH;
            mismatch_count = 0;
            awaited_results.delete();
            results_owed  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                req        = 32'(cfg_data);
                ring_slots = (req == 0) ? 1 : (req > RING_DEPTH ? RING_DEPTH : req);
                head_pos   = 0;
                tail_pos   = 0;
            end
            // The result side is checked first, so a word accepted in the same
            // cycle can never be mistaken for the one being answered.
            if (result.valid && result.ready)
            begin
                got.status       = status_t'(result.status);
                got.data_out     = result.data_out;
                got.match_offset = result.match_offset;
                got.is_empty     = result.is_empty;
                got.is_full      = result.is_full;
                if (awaited_results.size() == 0)
                begin
                    note_mismatch("unexpected result word", 0, got);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.status != want.status)
                        note_mismatch("status", want.status, got.status);
                    if (got.data_out != want.data_out)
                        note_mismatch("data_out", want.data_out, got.data_out);
                    if (got.match_offset != want.match_offset)
                        note_mismatch("match_offset", want.match_offset, got.match_offset);
                    if (got.is_empty != want.is_empty)
                        note_mismatch("is_empty", want.is_empty, got.is_empty);
                    if (got.is_full != want.is_full)
                        note_mismatch("is_full", want.is_full, got.is_full);
                end
            end
            if (item.valid && item.ready)
            begin
                awaited_results.push_back(apply_ring_action(action_t'(item.action),
                    item.data_in, item.pattern, item.pattern_len));
            end
            results_owed <= awaited_results.size();
        end
    end

endmodule

// ===== test/ring_fifo_with_pattern_search_test.sv =====
module ring_fifo_with_pattern_search_test;
    import rfps_pkg::*;

    localparam int CLK_PERIOD       = 10;
    // The slowest correct run is every word a find over a nearly full ring, with
    // the receiver's stalls on top; this allows several times that.
    localparam int RUN_LIMIT_CYCLES = 1_000_000;
    localparam int PHASE_COUNT      = 9;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CAP_CFG_W-1:0] cfg_data;

    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   mismatch_count;
    int                   results_owed;

    // A pair of byte values per phase; most data and pattern bytes are drawn
    // from it so that searches over the ring actually find something.
    logic [DATA_W-1:0]    sym_lo;
    logic [DATA_W-1:0]    sym_hi;

    // Capacity written at the start of each random phase and the number of
    // words sent in it. Zero acts as one slot, and 127 and 100 saturate to the
    // full depth.
    int unsigned          phase_caps  [PHASE_COUNT] = '{2, 0, 127, 64, 9, 1, 100, 33, 17};
    int unsigned          phase_words [PHASE_COUNT] = '{120, 40, 260, 260, 160, 40, 260, 200, 260};

    rfps_in_if  item ();
    rfps_out_if result ();

    ring_fifo_with_pattern_search u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item),
        .result   (result)
    );

    rfps_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .item           (item),
        .result         (result),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a result word.
    initial
    begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("TB_ERROR");
        $finish;
    end

    // The receiver drops ready at random, at whatever rate the current phase
    // asks for; ready is held low throughout reset.
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offers one word and returns at the edge where it is taken. Any idle
    // cycles are inserted before the word, never while it is on offer, so the
    // payload stays stable until the handshake completes.
    task automatic offer_word(
        action_t              act,
        logic [DATA_W-1:0]    din,
        logic [PATTERN_W-1:0] pat,
        logic [PLEN_W-1:0]    plen
    );
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid       <= 1'b1;
        item.action      <= act;
        item.data_in     <= din;
        item.pattern     <= pat;
        item.pattern_len <= plen;
        @(posedge clk);
        while (!item.ready) @(posedge clk);
    endtask

    // Holds the sender back until every word sent so far has been answered,
    // then lets a few more cycles go by so that the block is truly idle.
    task automatic settle();
        item.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // A capacity write empties the ring, so it only happens once the block
    // has gone quiet.
    task automatic set_capacity(int unsigned slots);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= slots[CAP_CFG_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] draw_byte(bit narrow);
        if (narrow)
            return $urandom_range(0, 1) ? sym_hi : sym_lo;
        return DATA_W'($urandom_range(0, 255));
    endfunction

    // One random word. put_pct sets how strongly the mix pushes the fill level
    // upwards; gets and peeks take what is left of the first four fifths and finds the last fifth.
    task automatic send_random_word(int unsigned put_pct);
        int unsigned          roll;
        bit                   narrow;
        action_t              act;
        logic [DATA_W-1:0]    din;
        logic [PATTERN_W-1:0] pat;
        logic [PLEN_W-1:0]    plen;
        roll   = $urandom_range(0, 99);
        narrow = ($urandom_range(0, 3) != 0);
        if (roll < put_pct)
            act = ACT_PUT;
        else if (roll < 80)
            act = ($urandom_range(0, 3) == 0) ? ACT_PEEK : ACT_GET;
        else
            act = ACT_FIND;
        din = draw_byte(narrow);
        for (int i = 0; i < 8; i++)
        begin
            pat[8*i +: 8] = draw_byte(narrow);
        end
        roll = $urandom_range(0, 9);
        if (roll < 6)
            plen = PLEN_W'($urandom_range(1, 4));
        else if (roll < 9)
            plen = PLEN_W'($urandom_range(5, 8));
        else
            plen = PLEN_W'($urandom_range(0, 15));
        offer_word(act, din, pat, plen);
    endtask

    initial
    begin
        int unsigned put_pct;
        int unsigned burst_left;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_data         <= '0;
        item.valid       <= 1'b0;
        item.action      <= ACT_PUT;
        item.data_in     <= '0;
        item.pattern     <= '0;
        item.pattern_len <= '0;
        send_idle_pct     = 22;
        recv_idle_pct     = 53;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset capacity: reads and a search on the empty
        // ring, then the extreme byte values, the zero length, lengths above
        // the pattern limit and a length above the fill level.
        offer_word(ACT_GET,  8'h00, '0, 4'd0);
        offer_word(ACT_PEEK, 8'hFF, '1, 4'd15);
        offer_word(ACT_FIND, 8'h00, '0, 4'd1);
        offer_word(ACT_PUT,  8'h00, '0, 4'd0);
        offer_word(ACT_PUT,  8'hFF, '0, 4'd0);
        offer_word(ACT_PEEK, 8'h00, '0, 4'd0);
        offer_word(ACT_FIND, 8'h00, '0, 4'd0);
        offer_word(ACT_FIND, 8'h00, 64'hFF00, 4'd9);
        offer_word(ACT_FIND, 8'h00, 64'hFF00, 4'd15);
        offer_word(ACT_FIND, 8'h00, 64'hFF00, 4'd3);
        offer_word(ACT_FIND, 8'h00, 64'hFF00, 4'd2);
        offer_word(ACT_FIND, 8'h00, 64'hFF, 4'd1);
        offer_word(ACT_GET,  8'h00, '0, 4'd0);
        offer_word(ACT_GET,  8'h00, '0, 4'd0);
        offer_word(ACT_GET,  8'h00, '0, 4'd0);

        // A four-slot ring: fill it, try one put too many, search it, and then
        // wrap the write position back to slot zero and search again.
        set_capacity(4);
        offer_word(ACT_PUT,  8'h11, '0, 4'd0);
        offer_word(ACT_PUT,  8'h22, '0, 4'd0);
        offer_word(ACT_PUT,  8'h33, '0, 4'd0);
        offer_word(ACT_PUT,  8'h44, '0, 4'd0);
        offer_word(ACT_FIND, 8'h00, '1, 4'd8);
        offer_word(ACT_FIND, 8'h00, 64'h33_2211, 4'd3);
        offer_word(ACT_GET,  8'h00, '0, 4'd0);
        offer_word(ACT_PUT,  8'h55, '0, 4'd0);
        offer_word(ACT_FIND, 8'h00, 64'h5533, 4'd2);
        offer_word(ACT_PEEK, 8'h00, '0, 4'd0);

        // Random phases. The first three stall the receiver more than the
        // sender, the next three the other way round, and the last three run
        // flat out. Within a phase the mix shifts between filling and
        // draining bursts so that the fill level sweeps from empty to full.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 53;
            end
            else if (p < 6)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sym_lo = DATA_W'($urandom_range(0, 255));
            sym_hi = DATA_W'($urandom_range(0, 255));
            set_capacity(phase_caps[p]);
            burst_left = 0;
            put_pct    = 45;
            for (int unsigned n = 0; n < phase_words[p]; n++)
            begin
                if (burst_left == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       put_pct = 20;
                        1:       put_pct = 45;
                        default: put_pct = 75;
                    endcase
                    burst_left = $urandom_range(20, 120);
                end
                burst_left--;
                // Halfway through, the sender waits for every outstanding
                // result before carrying on.
                if (n == phase_words[p] / 2)
                    settle();
                send_random_word(put_pct);
            end
        end

        settle();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
